>>> rtl/mp2x2_pkg.sv
// ----------------------------------------------------------------------------
// mp2x2_pkg
// Shared types and constants of the 2x2 max pooling block: register indexes,
// register reset values, field widths and the window tag record.
// ----------------------------------------------------------------------------
package mp2x2_pkg;

   localparam int IDX_W       = 8;
   localparam int MAP_SIZE_W  = 9;
   localparam int STRIDE_W    = 3;
   localparam int PHASE_W     = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 9;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_SIZE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRIDE   = 1'b1;

   localparam logic [MAP_SIZE_W-1:0] MAP_SIZE_RESET = 9'd224;
   localparam logic [STRIDE_W-1:0]   STRIDE_RESET   = 3'd2;
   localparam logic [STRIDE_W-1:0]   STRIDE_MIN     = 3'd1;
   localparam logic [STRIDE_W-1:0]   STRIDE_MAX     = 3'd4;

   typedef struct packed {
      logic [IDX_W-1:0] out_row;
      logic [IDX_W-1:0] out_col;
      logic             last_in_map;
   } win_tag_type;

   localparam int TAG_W = $bits(win_tag_type);

   function automatic logic [STRIDE_W-1:0] clamp_stride(input logic [STRIDE_W-1:0] v);
      logic [STRIDE_W-1:0] r;
      r = v;
      if (v < STRIDE_MIN) begin
         r = STRIDE_MIN;
      end else if (v > STRIDE_MAX) begin
         r = STRIDE_MAX;
      end
      return r;
   endfunction

   // Phase of the next position: zero after position zero, else one more
   // modulo the stride.
   function automatic logic [PHASE_W-1:0] next_phase(input logic          pos_zero,
                                                     input logic [PHASE_W-1:0] phase,
                                                     input logic [STRIDE_W-1:0] st);
      logic [STRIDE_W-1:0] inc;
      logic [PHASE_W-1:0]  r;
      inc = STRIDE_W'(phase) + STRIDE_W'(1);
      if (pos_zero || inc >= st) begin
         r = '0;
      end else begin
         r = inc[PHASE_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/mp2x2_queue.sv
// ----------------------------------------------------------------------------
// mp2x2_queue
// Small first-in first-out buffer of window records between the front and
// the back of the pooling block.
// ----------------------------------------------------------------------------
module mp2x2_queue #(
   parameter int WIDTH = 81,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/mp2x2_front.sv
// ----------------------------------------------------------------------------
// mp2x2_front
// Accepts samples, tracks the raster position against the configured map
// size and stride, keeps the previous row in a line store and hands each
// completed 2x2 window to the queue.
// ----------------------------------------------------------------------------
module mp2x2_front #(
   parameter int MAX_WIDTH   = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   input  logic [mp2x2_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mp2x2_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                  req_push,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample,
   input  logic                                  q_full,
   output logic                                  win_push,
   output logic [4*SAMPLE_BITS-1:0]              win_samples,
   output mp2x2_pkg::win_tag_type                win_tag
);

   localparam int POS_W  = $clog2(MAX_WIDTH);
   localparam int SIZE_W = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W  = SIZE_W + 1;
   localparam int IW     = mp2x2_pkg::IDX_W;
   localparam int PW     = mp2x2_pkg::PHASE_W;
   localparam int SW     = mp2x2_pkg::STRIDE_W;

   function automatic logic [SIZE_W-1:0] clamp_size(
      input logic [mp2x2_pkg::MAP_SIZE_W-1:0] v);
      int r;
      r = int'(v);
      if (r < 2) begin
         r = 2;
      end else if (r > MAX_WIDTH) begin
         r = MAX_WIDTH;
      end
      return SIZE_W'(r);
   endfunction

   logic [SIZE_W-1:0]      size_ff;
   logic [SW-1:0]          stride_ff;
   logic [POS_W-1:0]       row_ff, row_in;
   logic [POS_W-1:0]       col_ff, col_in;
   logic [PW-1:0]          row_phase_ff, row_phase_in;
   logic [PW-1:0]          col_phase_ff, col_phase_in;
   logic [IW-1:0]          out_row_ff, out_row_in;
   logic [IW-1:0]          out_col_ff, out_col_in;
   logic                   had_win_ff, had_win_in;
   logic [SAMPLE_BITS-1:0] left_ff, left_in;
   logic [SAMPLE_BITS-1:0] upper_left_ff, upper_left_in;
   logic [SAMPLE_BITS-1:0] rd_ff;
   logic [SAMPLE_BITS-1:0] line_mem [MAX_WIDTH];
   logic                   accept;
   logic                   emit;
   logic                   last_row, last_col, row_end, map_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= clamp_size(mp2x2_pkg::MAP_SIZE_RESET);
         stride_ff <= mp2x2_pkg::STRIDE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            mp2x2_pkg::CSR_MAP_SIZE: begin
               size_ff <= clamp_size(csr_data);
            end
            mp2x2_pkg::CSR_STRIDE: begin
               stride_ff <= mp2x2_pkg::clamp_stride(csr_data[SW-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   assign accept = req_push && !q_full;

   // The window closes on its bottom-right sample: both phases back at zero.
   assign emit = accept && (row_ff != '0) && (col_ff != '0)
                 && (row_phase_ff == '0) && (col_phase_ff == '0);

   assign last_row = (CMP_W'(row_ff) + CMP_W'(stride_ff)) >= CMP_W'(size_ff);
   assign last_col = (CMP_W'(col_ff) + CMP_W'(stride_ff)) >= CMP_W'(size_ff);
   assign row_end  = (CMP_W'(col_ff) + CMP_W'(1)) >= CMP_W'(size_ff);
   assign map_end  = (CMP_W'(row_ff) + CMP_W'(1)) >= CMP_W'(size_ff);

   always_comb begin
      row_in        = row_ff;
      col_in        = col_ff;
      row_phase_in  = row_phase_ff;
      col_phase_in  = col_phase_ff;
      out_row_in    = out_row_ff;
      out_col_in    = out_col_ff;
      had_win_in    = had_win_ff;
      left_in       = left_ff;
      upper_left_in = upper_left_ff;
      if (accept) begin
         left_in       = req_sample;
         upper_left_in = rd_ff;
         if (row_end) begin
            col_in       = '0;
            col_phase_in = '0;
            out_col_in   = '0;
            had_win_in   = 1'b0;
            if (had_win_ff || emit) begin
               out_row_in = out_row_ff + IW'(1);
            end
            if (map_end) begin
               row_in       = '0;
               row_phase_in = '0;
               out_row_in   = '0;
            end else begin
               row_in       = row_ff + POS_W'(1);
               row_phase_in = mp2x2_pkg::next_phase(row_ff == '0, row_phase_ff, stride_ff);
            end
         end else begin
            col_in       = col_ff + POS_W'(1);
            col_phase_in = mp2x2_pkg::next_phase(col_ff == '0, col_phase_ff, stride_ff);
            out_col_in   = out_col_ff + IW'(emit);
            had_win_in   = had_win_ff || emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff        <= '0;
         col_ff        <= '0;
         row_phase_ff  <= '0;
         col_phase_ff  <= '0;
         out_row_ff    <= '0;
         out_col_ff    <= '0;
         had_win_ff    <= 1'b0;
         left_ff       <= '0;
         upper_left_ff <= '0;
      end else begin
         row_ff        <= row_in;
         col_ff        <= col_in;
         row_phase_ff  <= row_phase_in;
         col_phase_ff  <= col_phase_in;
         out_row_ff    <= out_row_in;
         out_col_ff    <= out_col_in;
         had_win_ff    <= had_win_in;
         left_ff       <= left_in;
         upper_left_ff <= upper_left_in;
      end
   end

   // The read address runs one position ahead, so the sample above the next
   // beat is already registered when that beat arrives. The write address and
   // the next read address never coincide on an accepted beat.
   always_ff @(posedge clock) begin
      if (accept) begin
         line_mem[col_ff] <= req_sample;
      end
      rd_ff <= line_mem[col_in];
   end

   assign win_push            = emit;
   assign win_samples         = {req_sample, rd_ff, left_ff, upper_left_ff};
   assign win_tag.out_row     = out_row_ff;
   assign win_tag.out_col     = out_col_ff;
   assign win_tag.last_in_map = last_row && last_col;

endmodule

>>> rtl/mp2x2_back.sv
// ----------------------------------------------------------------------------
// mp2x2_back
// Takes window records from the queue, reduces the four samples to their
// signed maximum and holds the result in the output register.
// ----------------------------------------------------------------------------
module mp2x2_back #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_empty,
   input  logic [4*SAMPLE_BITS-1:0]              q_samples,
   input  mp2x2_pkg::win_tag_type                q_tag,
   output logic                                  q_pop,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic signed [SAMPLE_BITS-1:0]         rsp_pooled_value,
   output logic [mp2x2_pkg::IDX_W-1:0]           rsp_out_row,
   output logic [mp2x2_pkg::IDX_W-1:0]           rsp_out_col,
   output logic                                  rsp_last_in_map
);

   localparam int SB = SAMPLE_BITS;

   logic signed [SB-1:0]        s0, s1, s2, s3, m01, m23, best;
   logic                        valid_ff;
   logic signed [SB-1:0]        value_ff;
   mp2x2_pkg::win_tag_type      tag_ff;
   logic                        load;

   always_comb begin
      s0   = q_samples[4*SB-1:3*SB];
      s1   = q_samples[3*SB-1:2*SB];
      s2   = q_samples[2*SB-1:SB];
      s3   = q_samples[SB-1:0];
      m01  = (s1 > s0) ? s1 : s0;
      m23  = (s3 > s2) ? s3 : s2;
      best = (m23 > m01) ? m23 : m01;
   end

   assign load  = !q_empty && (!valid_ff || rsp_pop);
   assign q_pop = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= best;
         tag_ff   <= q_tag;
      end
   end

   assign rsp_empty        = !valid_ff;
   assign rsp_pooled_value = value_ff;
   assign rsp_out_row      = tag_ff.out_row;
   assign rsp_out_col      = tag_ff.out_col;
   assign rsp_last_in_map  = tag_ff.last_in_map;

endmodule

>>> rtl/max_pool_2x2.sv
// ----------------------------------------------------------------------------
// max_pool_2x2
// 2x2 max pooling with a configurable stride over a stream of square feature
// maps in raster order.
// ----------------------------------------------------------------------------
//  channel   direction   handshake            payload
//  req       in          push / full          sample
//  rsp       out         empty / pop          pooled_value, out_row, out_col,
//                                              last_in_map
//  csr       in          valid / ready        index, data (map_size, stride)
//
// One sample is taken every cycle while full is low; the line store is read
// one position ahead so it keeps up. A pooled result passes through the
// window queue and the output register before it reaches the rsp ports.
// Reset is synchronous; the line store is not cleared and is filled by the
// first row of each map. full rises only when the window queue holds four
// records while the output register is not popped.
// ----------------------------------------------------------------------------
module max_pool_2x2 #(
   parameter int MAX_WIDTH   = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic signed [SAMPLE_BITS-1:0]         rsp_pooled_value,
   output logic [mp2x2_pkg::IDX_W-1:0]           rsp_out_row,
   output logic [mp2x2_pkg::IDX_W-1:0]           rsp_out_col,
   output logic                                  rsp_last_in_map,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mp2x2_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mp2x2_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int SAMP4_W = 4 * SAMPLE_BITS;
   localparam int REC_W   = SAMP4_W + mp2x2_pkg::TAG_W;

   logic                   q_full, q_empty, q_pop, win_push;
   logic [SAMP4_W-1:0]     win_samples;
   mp2x2_pkg::win_tag_type win_tag, q_tag;
   logic [REC_W-1:0]       q_data;

   assign csr_ready = 1'b1;
   assign req_full  = q_full;

   mp2x2_front #(
      .MAX_WIDTH   (MAX_WIDTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_push    (req_push),
      .req_sample  (req_sample),
      .q_full      (q_full),
      .win_push    (win_push),
      .win_samples (win_samples),
      .win_tag     (win_tag)
   );

   mp2x2_queue #(
      .WIDTH (REC_W),
      .DEPTH (mp2x2_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (win_push),
      .push_data ({win_samples, win_tag}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   assign q_tag = q_data[mp2x2_pkg::TAG_W-1:0];

   mp2x2_back #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_samples        (q_data[REC_W-1:mp2x2_pkg::TAG_W]),
      .q_tag            (q_tag),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_pooled_value (rsp_pooled_value),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_col      (rsp_out_col),
      .rsp_last_in_map  (rsp_last_in_map)
   );

endmodule

>>> rtl/mp2x2_checker.sv
// ----------------------------------------------------------------------------
// mp2x2_checker
// Port-level checks on the pooling block, bound to its top level.
// ----------------------------------------------------------------------------
module mp2x2_checker #(
   parameter int SAMPLE_BITS = 16
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_push,
   input logic                                  req_full,
   input logic                                  rsp_empty,
   input logic                                  rsp_pop,
   input logic signed [SAMPLE_BITS-1:0]         rsp_pooled_value,
   input logic [mp2x2_pkg::IDX_W-1:0]           rsp_out_row,
   input logic [mp2x2_pkg::IDX_W-1:0]           rsp_out_col,
   input logic                                  rsp_last_in_map,
   input logic                                  csr_valid,
   input logic                                  csr_ready
);

   // After reset nothing is waiting and the input side is open.
   a_reset_clean: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("result pending or input blocked right after reset");

   // The queue only fills through a window beat pushed at the edge before.
   a_full_needs_push: assert property (@(posedge clock) disable iff (reset)
      $rose(req_full) |-> $past(req_push))
      else $error("input side became full without a pushed beat");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty)
      else $error("result beat withdrawn before it was popped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> $stable(rsp_pooled_value) && $stable(rsp_out_row)
                               && $stable(rsp_out_col) && $stable(rsp_last_in_map))
      else $error("result beat changed while stalled");

   // Register writes are taken in the cycle they are offered.
   a_csr_taken: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write beat not taken");

endmodule

bind max_pool_2x2 mp2x2_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_mp2x2_checker (
   .clock            (clock),
   .reset            (reset),
   .req_push         (req_push),
   .req_full         (req_full),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_pooled_value (rsp_pooled_value),
   .rsp_out_row      (rsp_out_row),
   .rsp_out_col      (rsp_out_col),
   .rsp_last_in_map  (rsp_last_in_map),
   .csr_valid        (csr_valid),
   .csr_ready        (csr_ready)
);

>>> dv/tb_max_pool_2x2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_pool_2x2
// Self-checking testbench for the 2x2 max pooling block. Samples are pushed
// in raster order under several map sizes and strides, with mid-map writes.
// A predictor tracks the line store, the window position and the counters,
// and every popped result is compared field by field with the oldest
// expected window.
// ----------------------------------------------------------------------------
module tb_max_pool_2x2;

   localparam int MAX_W         = 256;
   localparam int POS_B         = $clog2(MAX_W);
   localparam int SBITS         = 16;
   localparam int SETTLE_CYCLES = 6;

   typedef struct {
      logic signed [SBITS-1:0]         pooled_value;
      logic [mp2x2_pkg::IDX_W-1:0]     out_row;
      logic [mp2x2_pkg::IDX_W-1:0]     out_col;
      logic                            last_in_map;
   } pool_result_type;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_push;
   logic                                req_full;
   logic signed [SBITS-1:0]             req_sample;
   logic                                rsp_empty;
   logic                                rsp_pop;
   logic signed [SBITS-1:0]             rsp_pooled_value;
   logic [mp2x2_pkg::IDX_W-1:0]         rsp_out_row;
   logic [mp2x2_pkg::IDX_W-1:0]         rsp_out_col;
   logic                                rsp_last_in_map;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [mp2x2_pkg::CSR_INDEX_W-1:0]   csr_index;
   logic [mp2x2_pkg::CSR_DATA_W-1:0]    csr_data;

   // Predictor state.
   logic [mp2x2_pkg::MAP_SIZE_W-1:0]    cfg_size;
   logic [mp2x2_pkg::STRIDE_W-1:0]      cfg_stride;
   logic signed [SBITS-1:0]             prev_row [MAX_W];
   logic signed [SBITS-1:0]             left_q;
   logic signed [SBITS-1:0]             upper_left_q;
   int unsigned                         row_pos;
   int unsigned                         col_pos;
   int unsigned                         row_phase;
   int unsigned                         col_phase;
   int unsigned                         win_row;
   int unsigned                         win_col;
   pool_result_type                     pending_pools[$];
   pool_result_type                     oldest;

   int unsigned push_gap_pct;
   int unsigned pop_stall_pct;
   int unsigned samples_sent;
   int unsigned results_checked;
   int unsigned maps_done;
   int unsigned cfg_writes;
   int unsigned errors;

   max_pool_2x2 dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_sample       (req_sample),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_pooled_value (rsp_pooled_value),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_col      (rsp_out_col),
      .rsp_last_in_map  (rsp_last_in_map),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned active_size();
      if (cfg_size < 2) begin
         return 2;
      end
      if (cfg_size > MAX_W) begin
         return MAX_W;
      end
      return 32'(cfg_size);
   endfunction

   function automatic int unsigned active_stride();
      if (cfg_stride == 0) begin
         return 1;
      end
      if (cfg_stride > 4) begin
         return 4;
      end
      return 32'(cfg_stride);
   endfunction

   function automatic int unsigned advance_phase(input int unsigned old_pos,
                                                 input int unsigned phase,
                                                 input int unsigned st);
      if (old_pos == 0) begin
         return 0;
      end
      return (phase + 1 >= st) ? 0 : phase + 1;
   endfunction

   function automatic logic signed [SBITS-1:0] pick_sample();
      case ($urandom_range(9))
         0: return {1'b1, {(SBITS-1){1'b0}}};
         1: return {1'b0, {(SBITS-1){1'b1}}};
         2: return '0;
         default: return SBITS'($urandom);
      endcase
   endfunction

   // Advances the window position by one sample and queues the pooled value
   // when the sample closes a window.
   task automatic pool_window_update(input logic signed [SBITS-1:0] cur);
      int unsigned             size;
      int unsigned             st;
      logic signed [SBITS-1:0] upper;
      logic signed [SBITS-1:0] best;
      pool_result_type         res;
      size  = active_size();
      st    = active_stride();
      upper = prev_row[POS_B'(col_pos)];
      if (row_pos >= 1 && col_pos >= 1 && row_phase == 0 && col_phase == 0) begin
         best = cur;
         if (upper > best) begin
            best = upper;
         end
         if (left_q > best) begin
            best = left_q;
         end
         if (upper_left_q > best) begin
            best = upper_left_q;
         end
         res.pooled_value = best;
         res.out_row      = mp2x2_pkg::IDX_W'(win_row);
         res.out_col      = mp2x2_pkg::IDX_W'(win_col);
         res.last_in_map  = (row_pos + st >= size) && (col_pos + st >= size);
         pending_pools.push_back(res);
         win_col++;
      end
      upper_left_q                = upper;
      left_q                      = cur;
      prev_row[POS_B'(col_pos)]   = cur;
      if (col_pos + 1 >= size) begin
         col_pos   = 0;
         col_phase = 0;
         if (win_col != 0) begin
            win_row++;
         end
         win_col = 0;
         if (row_pos + 1 >= size) begin
            row_pos   = 0;
            row_phase = 0;
            win_row   = 0;
            maps_done++;
         end else begin
            row_pos++;
            row_phase = advance_phase(row_pos - 1, row_phase, st);
         end
      end else begin
         col_pos++;
         col_phase = advance_phase(col_pos - 1, col_phase, st);
      end
   endtask

   // Called at a falling edge; returns at the falling edge after the beat.
   task automatic send_sample(input logic signed [SBITS-1:0] s);
      while ($urandom_range(99) < push_gap_pct) begin
         req_push   <= 1'b0;
         req_sample <= SBITS'($urandom);
         @(negedge clock);
      end
      req_push   <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (req_full) begin
         @(posedge clock);
      end
      pool_window_update(s);
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic send_rest_of_map();
      do begin
         send_sample(pick_sample());
      end while (row_pos != 0 || col_pos != 0);
   endtask

   // Holds the sender off until every expected window has been popped, then
   // lets the pipeline settle so that a register write finds the block idle.
   task automatic drain_results();
      req_push <= 1'b0;
      while (pending_pools.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [mp2x2_pkg::CSR_INDEX_W-1:0] idx,
                            input int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= mp2x2_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      if (idx == mp2x2_pkg::CSR_MAP_SIZE) begin
         cfg_size = mp2x2_pkg::MAP_SIZE_W'(value);
      end else begin
         cfg_stride = mp2x2_pkg::STRIDE_W'(value);
      end
      cfg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Register values below and above the legal range, and the extreme
   // sample values, on the smallest maps.
   task automatic test_clamped_tiny_maps();
      csr_write(mp2x2_pkg::CSR_MAP_SIZE, 0);
      csr_write(mp2x2_pkg::CSR_STRIDE, 7);
      repeat (4) send_sample({1'b1, {(SBITS-1){1'b0}}});
      drain_results();
      csr_write(mp2x2_pkg::CSR_MAP_SIZE, 1);
      csr_write(mp2x2_pkg::CSR_STRIDE, 0);
      send_sample({1'b0, {(SBITS-1){1'b1}}});
      send_sample(SBITS'(-1));
      send_sample(SBITS'(0));
      send_sample({1'b1, {(SBITS-1){1'b0}}});
      drain_results();
      csr_write(mp2x2_pkg::CSR_MAP_SIZE, 2);
      csr_write(mp2x2_pkg::CSR_STRIDE, 4);
      send_sample(SBITS'(-1));
      send_sample(SBITS'(0));
      send_sample(SBITS'(1));
      send_sample(SBITS'(-2));
      drain_results();
   endtask

   // Shrinking the map and changing the stride while a map is half done.
   task automatic test_midmap_writes();
      csr_write(mp2x2_pkg::CSR_MAP_SIZE, 3);
      csr_write(mp2x2_pkg::CSR_STRIDE, 1);
      repeat (5) send_sample(pick_sample());
      drain_results();
      csr_write(mp2x2_pkg::CSR_MAP_SIZE, 2);
      send_rest_of_map();
      drain_results();
      csr_write(mp2x2_pkg::CSR_MAP_SIZE, 3);
      repeat (4) send_sample(pick_sample());
      drain_results();
      // From here on the last row holds no window, so the output row
      // counter must not advance for it.
      csr_write(mp2x2_pkg::CSR_STRIDE, 3);
      send_rest_of_map();
      drain_results();
   endtask

   // Full-width rows with the size register above its range; the map is cut
   // short after two rows by shrinking the size.
   task automatic test_wide_rows();
      drain_results();
      csr_write(mp2x2_pkg::CSR_MAP_SIZE, 511);
      csr_write(mp2x2_pkg::CSR_STRIDE, 1);
      repeat (2 * MAX_W) send_sample(pick_sample());
      drain_results();
      csr_write(mp2x2_pkg::CSR_MAP_SIZE, 2);
      send_rest_of_map();
      drain_results();
   endtask

   // Whole maps of small random size and stride, some with a register
   // write part way through.
   task automatic test_random_maps(input int unsigned item_goal);
      int unsigned start;
      int unsigned size;
      int unsigned mid_at;
      start = samples_sent;
      while (samples_sent - start < item_goal) begin
         drain_results();
         csr_write(mp2x2_pkg::CSR_MAP_SIZE, $urandom_range(0, 8));
         csr_write(mp2x2_pkg::CSR_STRIDE, $urandom_range(0, 7) | ($urandom_range(0, 63) << 3));
         repeat ($urandom_range(1, 3)) begin
            size   = active_size();
            mid_at = ($urandom_range(4) == 0) ? $urandom_range(1, size * size - 1) : 0;
            if (mid_at != 0) begin
               repeat (mid_at) send_sample(pick_sample());
               drain_results();
               // Only a size no larger than the current one is safe: a larger
               // one would read line store entries this map never wrote.
               if ($urandom_range(1) == 0) begin
                  csr_write(mp2x2_pkg::CSR_MAP_SIZE, $urandom_range(0, size));
               end else begin
                  csr_write(mp2x2_pkg::CSR_STRIDE, $urandom_range(0, 7));
               end
            end
            send_rest_of_map();
         end
      end
   endtask

   always @(negedge clock) begin
      rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_pools.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, expected none, got value %0d row %0d col %0d last %0b",
                     $time, rsp_pooled_value, rsp_out_row, rsp_out_col, rsp_last_in_map);
         end else begin
            oldest = pending_pools.pop_front();
            results_checked++;
            if (rsp_pooled_value !== oldest.pooled_value) begin
               errors++;
               $display("%0t: pooled_value expected %0d, got %0d",
                        $time, oldest.pooled_value, rsp_pooled_value);
            end
            if (rsp_out_row !== oldest.out_row) begin
               errors++;
               $display("%0t: out_row expected %0d, got %0d", $time, oldest.out_row, rsp_out_row);
            end
            if (rsp_out_col !== oldest.out_col) begin
               errors++;
               $display("%0t: out_col expected %0d, got %0d", $time, oldest.out_col, rsp_out_col);
            end
            if (rsp_last_in_map !== oldest.last_in_map) begin
               errors++;
               $display("%0t: last_in_map expected %0b, got %0b",
                        $time, oldest.last_in_map, rsp_last_in_map);
            end
         end
      end
   end

   initial begin
      reset           = 1'b1;
      req_push        = 1'b0;
      req_sample      = '0;
      rsp_pop         = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = mp2x2_pkg::CSR_MAP_SIZE;
      csr_data        = '0;
      cfg_size        = mp2x2_pkg::MAP_SIZE_RESET;
      cfg_stride      = mp2x2_pkg::STRIDE_RESET;
      left_q          = '0;
      upper_left_q    = '0;
      row_pos         = 0;
      col_pos         = 0;
      row_phase       = 0;
      col_phase       = 0;
      win_row         = 0;
      win_col         = 0;
      samples_sent    = 0;
      results_checked = 0;
      maps_done       = 0;
      cfg_writes      = 0;
      errors          = 0;
      push_gap_pct    = 8;
      pop_stall_pct   = 57;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      test_clamped_tiny_maps();
      test_midmap_writes();
      test_random_maps(30);

      push_gap_pct  = 57;
      pop_stall_pct = 8;
      test_wide_rows();
      test_random_maps(30);

      push_gap_pct  = 0;
      pop_stall_pct = 0;
      test_random_maps(30);
      drain_results();

      $display("Pushed %0d samples over %0d maps with %0d register writes.",
               samples_sent, maps_done, cfg_writes);
      $display("Checked %0d pooled windows; %0d mismatches.", results_checked, errors);
      if (errors == 0) begin
         $display("PASS max_pool_2x2");
      end else begin
         $display("FAIL max_pool_2x2");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d windows still expected.", pending_pools.size());
      $display("FAIL max_pool_2x2");
      $finish;
   end

endmodule

>>> filelist.f
rtl/mp2x2_pkg.sv
rtl/mp2x2_queue.sv
rtl/mp2x2_front.sv
rtl/mp2x2_back.sv
rtl/max_pool_2x2.sv
rtl/mp2x2_checker.sv
dv/tb_max_pool_2x2.sv
